// File: sv/ggpc_pkg.sv
package ggpc_pkg;

  // Fixed-point formats.
  localparam int POS_FRAC_BITS   = 10;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_STEPS    = 16;

  // CORDIC datapath: Q.30 angles, 34-bit signed words.
  localparam int CW         = 34;
  localparam int ATAN_LEN   = 24;
  localparam int ATAN_IDX_W = $clog2(ATAN_LEN);
  localparam int CNT_W      = $clog2(CORDIC_STEPS);
  localparam int ANG_SHIFT  = 30 - ANGLE_FRAC_BITS;
  localparam int VEC_SHIFT  = 12;

  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

  localparam logic signed [CW-1:0] ATAN_TAB [ATAN_LEN] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
    34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
    34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
    34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
    34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
    34'sd1023,      34'sd511,       34'sd255,       34'sd127
  };

  // Pi and two pi in the angle format, rounded to nearest.
  localparam longint PI_Q_L = (64'sd3373259426 + (64'sd1 << (ANG_SHIFT - 1))) >>> ANG_SHIFT;
  localparam logic signed [17:0] PI_Q  = 18'(PI_Q_L);
  localparam logic signed [17:0] TPI_Q = 18'(2 * PI_Q_L);

  // Gains in Q.16 and the slow-down rule, rescaled to the angle format.
  localparam logic signed [17:0] K_FWD = 18'sd39322;
  localparam logic signed [17:0] K_LAT = 18'sd22938;
  localparam logic signed [17:0] K_YAW = 18'sd88474;
  localparam int HEAD_LIM = (29491 + (1 << (15 - ANGLE_FRAC_BITS))) >> (16 - ANGLE_FRAC_BITS);
  localparam int SLOW_FWD = (7864 + (1 << (15 - ANGLE_FRAC_BITS))) >> (16 - ANGLE_FRAC_BITS);
  localparam int VEL_SHIFT = POS_FRAC_BITS + 32 - ANGLE_FRAC_BITS;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_POSE  = 2'd1,
    OP_IMU   = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_GOAL_X    = 3'd0,
    CFG_GOAL_Y    = 3'd1,
    CFG_RADIUS    = 3'd2,
    CFG_TURN_ANG  = 3'd3,
    CFG_TURN_TOL  = 3'd4,
    CFG_MAX_FWD   = 3'd5,
    CFG_MAX_LAT   = 3'd6,
    CFG_MAX_TURN  = 3'd7
  } cfg_idx_t;

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_NAV  = 2'd1;
  localparam logic [1:0] PH_ROT  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // Command to the CORDIC unit.
  typedef struct packed {
    logic                 start;
    logic                 vec;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [CW-1:0] z0;
  } cordic_cmd_t;

  // Wrap an angle into [-pi, pi] by steps of two pi.
  function automatic logic signed [15:0] wrap(input logic signed [17:0] a);
    logic signed [17:0] v;
    v = a;
    if (v > PI_Q) v = v - TPI_Q;
    if (v > PI_Q) v = v - TPI_Q;
    if (v < -PI_Q) v = v + TPI_Q;
    if (v < -PI_Q) v = v + TPI_Q;
    return v[15:0];
  endfunction

  // Right shift rounding to nearest, ties away from zero.
  function automatic logic signed [52:0] rshr(input logic signed [52:0] v, input int s);
    logic signed [52:0] h;
    h = 53'sd1 <<< (s - 1);
    if (v < 0) return (v + h - 53'sd1) >>> s;
    return (v + h) >>> s;
  endfunction

endpackage

// File: sv/ggpc_if.sv
interface ggpc_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] heading;
  logic               pose_valid;

  modport source (output valid, opcode, pos_x, pos_y, heading, pose_valid, input ready);
  modport sink (input valid, opcode, pos_x, pos_y, heading, pose_valid, output ready);
endinterface

interface ggpc_res_if;
  logic               valid;
  logic               ready;
  logic [13:0]        forward_vel;
  logic signed [14:0] lateral_vel;
  logic signed [14:0] turn_vel;
  logic [1:0]         phase;
  logic               arrived;

  modport source (output valid, forward_vel, lateral_vel, turn_vel, phase, arrived,
                  input ready);
  modport sink (input valid, forward_vel, lateral_vel, turn_vel, phase, arrived,
                output ready);
endinterface

// File: sv/go_to_goal_pose_controller_core.sv
// Go-to-goal pose controller core.
// Items arrive on the cmd channel (valid/ready): start, pose, IMU yaw or
// control tick. Only a control tick yields an item on the res channel: the
// body-frame velocity command, the phase and the arrival flag.
// Start, pose and IMU items are handled in the cycle that accepts them, and a
// tick while waiting (no goal or no feedback) goes straight to the output step.
// A navigating tick runs two 16-step CORDIC passes (sin/cos of yaw, then
// atan2 of the offset) and ten passes through the shared 18x34 multiplier. A
// rotating tick and the tick on which the goal is reached skip the CORDIC
// passes. The result is registered in the output step. cmd.ready is high
// only while no item is in work. The user must write configuration through
// cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce it.
// Reset (rst, synchronous) clears navigation and feedback state, restores the
// register defaults and empties the output register. The result sits in an
// output register; a new item is accepted while it waits, but a following
// tick holds in its last step until res.ready takes the previous result.
module go_to_goal_pose_controller_core import ggpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ggpc_cmd_if.sink    cmd,
  ggpc_res_if.source  res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_DIFF, S_SQX, S_SQY, S_SQR, S_ARRIVE, S_RERR, S_RMUL, S_RFIN,
    S_SCSTART, S_SCRUN, S_FB1, S_FB2, S_FB3, S_FB4, S_FB5, S_FWD, S_LAT,
    S_LATR, S_ATSTART, S_ATRUN, S_AERR, S_AMUL, S_AFIN, S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic signed [15:0] goal_x, goal_y;
  logic [12:0] arrive_radius;
  logic [14:0] turn_angle;
  logic [13:0] turn_tolerance, max_forward, max_lateral, max_turn_rate;

  // Controller state.
  logic navigating, rotating, have_pose, have_yaw;
  logic signed [15:0] rotate_goal_yaw, cur_x, cur_y, cur_yaw;

  // Working registers.
  logic signed [16:0]   dx, dy;
  logic signed [52:0]   acc;
  logic signed [CW-1:0] cv, sv, fbs, lbs;
  logic signed [15:0]   err, ang;
  logic                 neg;
  logic [13:0]          w_fwd;
  logic signed [14:0]   w_lat, w_turn;
  logic [1:0]           w_phase;
  logic                 w_arr;

  // Shared units.
  logic signed [17:0]   mul_a;
  logic signed [CW-1:0] mul_b;
  logic signed [51:0]   mul_p;
  cordic_cmd_t          ccmd;
  logic                 c_done;
  logic signed [CW-1:0] c_x, c_y, c_z;

  ggpc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  ggpc_cordic u_cordic (
    .clk(clk), .rst(rst), .cmd(ccmd), .done(c_done), .x(c_x), .y(c_y), .z(c_z)
  );

  assign cmd.ready = (state == S_IDLE);

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQX:   begin mul_a = 18'(dx);            mul_b = CW'(dx); end
      S_SQY:   begin mul_a = 18'(dy);            mul_b = CW'(dy); end
      S_SQR:   begin mul_a = 18'(arrive_radius); mul_b = CW'(arrive_radius); end
      S_RMUL:  begin mul_a = K_YAW;              mul_b = CW'(err); end
      S_FB1:   begin mul_a = 18'(dx);            mul_b = cv; end
      S_FB2:   begin mul_a = 18'(dy);            mul_b = sv; end
      S_FB3:   begin mul_a = 18'(dy);            mul_b = cv; end
      S_FB4:   begin mul_a = 18'(dx);            mul_b = sv; end
      S_FB5:   begin mul_a = K_FWD;              mul_b = fbs; end
      S_LAT:   begin mul_a = K_LAT;              mul_b = lbs; end
      S_AMUL:  begin mul_a = K_YAW;              mul_b = CW'(err); end
      default: begin mul_a = '0;                 mul_b = '0; end
    endcase
  end

  // CORDIC start: sin/cos of the yaw, or atan2 of the goal offset.
  logic signed [CW-1:0] sc_z;
  always_comb begin
    ccmd       = '0;
    sc_z       = CW'(wrap(18'(cur_yaw))) <<< ANG_SHIFT;
    if (sc_z > HALF_PI_Q30) sc_z = sc_z - PI_Q30;
    else if (sc_z < -HALF_PI_Q30) sc_z = sc_z + PI_Q30;
    if (state == S_SCSTART) begin
      ccmd.start = 1'b1;
      ccmd.vec   = 1'b0;
      ccmd.x0    = GAIN_Q30;
      ccmd.y0    = '0;
      ccmd.z0    = sc_z;
    end else if (state == S_ATSTART) begin
      ccmd.start = 1'b1;
      ccmd.vec   = 1'b1;
      ccmd.x0    = CW'(dx) <<< VEC_SHIFT;
      ccmd.y0    = CW'(dy) <<< VEC_SHIFT;
      ccmd.z0    = '0;
      if (dx < 0) begin
        ccmd.x0 = -(CW'(dx) <<< VEC_SHIFT);
        ccmd.y0 = -(CW'(dy) <<< VEC_SHIFT);
        ccmd.z0 = (dy >= 0) ? PI_Q30 : -PI_Q30;
      end
    end
  end

  // Rounded and clamped results from the multiplier output.
  logic signed [52:0] p_fwd, p_lat, p_turn, r_acc, r_z;
  logic signed [23:0] v_fwd, v_lat;
  logic signed [19:0] v_turn;
  logic signed [14:0] turn_cl;
  logic [16:0]        err_mag;
  logic signed [23:0] fwd_lim, lat_lim;
  logic signed [19:0] turn_lim;
  always_comb begin
    p_fwd    = rshr(53'(mul_p), VEL_SHIFT);
    p_lat    = rshr(53'(mul_p), VEL_SHIFT);
    p_turn   = rshr(53'(mul_p), 16);
    r_acc    = rshr(acc, 14);
    r_z      = rshr(53'(c_z), ANG_SHIFT);
    v_fwd    = p_fwd[23:0];
    v_lat    = p_lat[23:0];
    v_turn   = p_turn[19:0];
    fwd_lim  = 24'(max_forward);
    lat_lim  = 24'(max_lateral);
    turn_lim = 20'(max_turn_rate);
    if (v_turn < -turn_lim) turn_cl = -15'(max_turn_rate);
    else if (v_turn > turn_lim) turn_cl = 15'(max_turn_rate);
    else turn_cl = v_turn[14:0];
    err_mag = (err < 0) ? 17'(-17'(err)) : 17'(err);
  end

  // Sequencer, state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      goal_x          <= -16'sd102;
      goal_y          <= 16'sd1638;
      arrive_radius   <= 13'd205;
      turn_angle      <= 15'd21447;
      turn_tolerance  <= 14'd655;
      max_forward     <= 14'd2294;
      max_lateral     <= 14'd819;
      max_turn_rate   <= 14'd5734;
      navigating      <= 1'b0;
      rotating        <= 1'b0;
      have_pose       <= 1'b0;
      have_yaw        <= 1'b0;
      rotate_goal_yaw <= '0;
      cur_x           <= '0;
      cur_y           <= '0;
      cur_yaw         <= '0;
      res.valid       <= 1'b0;
    end else begin
      // The output step reloads the register itself when it is taken.
      if (res.valid && res.ready && state != S_OUT) res.valid <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_GOAL_X:   goal_x         <= cfg_wdata;
          CFG_GOAL_Y:   goal_y         <= cfg_wdata;
          CFG_RADIUS:   arrive_radius  <= cfg_wdata[12:0];
          CFG_TURN_ANG: turn_angle     <= cfg_wdata[14:0];
          CFG_TURN_TOL: turn_tolerance <= cfg_wdata[13:0];
          CFG_MAX_FWD:  max_forward    <= cfg_wdata[13:0];
          CFG_MAX_LAT:  max_lateral    <= cfg_wdata[13:0];
          CFG_MAX_TURN: max_turn_rate  <= cfg_wdata[13:0];
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            unique case (op_t'(cmd.opcode))
              OP_START: begin
                navigating <= 1'b1;
                rotating   <= 1'b0;
              end
              OP_POSE: begin
                if (cmd.pose_valid) begin
                  cur_x     <= cmd.pos_x;
                  cur_y     <= cmd.pos_y;
                  cur_yaw   <= cmd.heading;
                  have_pose <= 1'b1;
                  have_yaw  <= 1'b1;
                end
              end
              OP_IMU: begin
                cur_yaw  <= cmd.heading;
                have_yaw <= 1'b1;
              end
              OP_TICK: begin
                w_fwd   <= '0;
                w_lat   <= '0;
                w_turn  <= '0;
                w_phase <= PH_WAIT;
                w_arr   <= 1'b0;
                if ((navigating || rotating) && have_pose && have_yaw) state <= S_DIFF;
                else state <= S_OUT;
              end
            endcase
          end
        end
        S_DIFF: begin
          dx    <= 17'(goal_x) - 17'(cur_x);
          dy    <= 17'(goal_y) - 17'(cur_y);
          state <= navigating ? S_SQX : S_RERR;
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          acc   <= 53'(mul_p);
          state <= S_SQR;
        end
        S_SQR: begin
          acc   <= acc + 53'(mul_p);
          state <= S_ARRIVE;
        end
        S_ARRIVE: begin
          if (acc <= 53'(mul_p)) begin
            navigating      <= 1'b0;
            rotating        <= 1'b1;
            rotate_goal_yaw <= wrap(18'(cur_yaw) - 18'(turn_angle));
            w_arr           <= 1'b1;
            state           <= S_RERR;
          end else begin
            state <= S_SCSTART;
          end
        end
        // Rotation in place.
        S_RERR: begin
          err   <= wrap(18'(rotate_goal_yaw) - 18'(cur_yaw));
          state <= S_RMUL;
        end
        S_RMUL: state <= S_RFIN;
        S_RFIN: begin
          if (err_mag <= 17'(turn_tolerance)) begin
            rotating <= 1'b0;
            w_turn   <= '0;
            w_phase  <= PH_DONE;
          end else begin
            w_turn  <= turn_cl;
            w_phase <= PH_ROT;
          end
          state <= S_OUT;
        end
        // Navigation: rotate the offset into the body frame.
        S_SCSTART: begin
          neg   <= (CW'(wrap(18'(cur_yaw))) <<< ANG_SHIFT > HALF_PI_Q30) ||
                   (CW'(wrap(18'(cur_yaw))) <<< ANG_SHIFT < -HALF_PI_Q30);
          state <= S_SCRUN;
        end
        S_SCRUN: begin
          if (c_done) begin
            cv    <= neg ? -c_x : c_x;
            sv    <= neg ? -c_y : c_y;
            state <= S_FB1;
          end
        end
        S_FB1: state <= S_FB2;
        S_FB2: begin
          acc   <= 53'(mul_p);
          state <= S_FB3;
        end
        S_FB3: begin
          acc   <= acc + 53'(mul_p);
          state <= S_FB4;
        end
        S_FB4: begin
          fbs   <= r_acc[CW-1:0];
          acc   <= 53'(mul_p);
          state <= S_FB5;
        end
        S_FB5: begin
          acc   <= acc - 53'(mul_p);
          state <= S_FWD;
        end
        S_FWD: begin
          if (v_fwd < 0) w_fwd <= '0;
          else if (v_fwd > fwd_lim) w_fwd <= max_forward;
          else w_fwd <= v_fwd[13:0];
          lbs   <= r_acc[CW-1:0];
          state <= S_LAT;
        end
        S_LAT: state <= S_LATR;
        S_LATR: begin
          if (v_lat < -lat_lim) w_lat <= -15'(max_lateral);
          else if (v_lat > lat_lim) w_lat <= 15'(max_lateral);
          else w_lat <= v_lat[14:0];
          state <= S_ATSTART;
        end
        // Heading to the goal.
        S_ATSTART: state <= S_ATRUN;
        S_ATRUN: begin
          if (c_done) begin
            if (dx == 0 && dy == 0) ang <= '0;
            else ang <= wrap(r_z[17:0]);
            state <= S_AERR;
          end
        end
        S_AERR: begin
          err   <= wrap(18'(ang) - 18'(cur_yaw));
          state <= S_AMUL;
        end
        S_AMUL: state <= S_AFIN;
        S_AFIN: begin
          w_turn  <= turn_cl;
          w_phase <= PH_NAV;
          if (err_mag > 17'(HEAD_LIM) && w_fwd > 14'(SLOW_FWD)) w_fwd <= 14'(SLOW_FWD);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!res.valid || res.ready) begin
            res.valid       <= 1'b1;
            res.forward_vel <= w_fwd;
            res.lateral_vel <= w_lat;
            res.turn_vel    <= w_turn;
            res.phase       <= w_phase;
            res.arrived     <= w_arr;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Navigation and rotation never run together.
  a_modes_excl: assert property (@(posedge clk) disable iff (rst)
    !(navigating && rotating)) else $error("nav and rotate both active");

  // A waiting result carries no motion.
  a_wait_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.phase == PH_WAIT |->
      res.forward_vel == 0 && res.lateral_vel == 0 && res.turn_vel == 0 && !res.arrived)
    else $error("motion in waiting result");

  // Rotating results do not translate.
  a_rot_still: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.phase == PH_ROT || res.phase == PH_DONE) |->
      res.forward_vel == 0 && res.lateral_vel == 0)
    else $error("translation while rotating");

  // Arrival always starts the rotation on the same tick.
  a_arrive_rot: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.arrived |-> (res.phase == PH_ROT || res.phase == PH_DONE))
    else $error("arrival without rotation phase");

  // A tick keeps the block busy in the following cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready && cmd.opcode == OP_TICK |=> !cmd.ready)
    else $error("ready right after a tick");

endmodule

// File: sv/ggpc_mul.sv
module ggpc_mul import ggpc_pkg::*; (
  input  logic                 clk,
  input  logic signed [17:0]   a,
  input  logic signed [CW-1:0] b,
  output logic signed [51:0]   p
);

  // Shared signed multiplier; the product is registered.
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: sv/ggpc_cordic.sv
module ggpc_cordic import ggpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cordic_cmd_t          cmd,
  output logic                 done,
  output logic signed [CW-1:0] x,
  output logic signed [CW-1:0] y,
  output logic signed [CW-1:0] z
);

  logic             busy;
  logic             vec;
  logic [CNT_W-1:0] cnt;
  logic signed [CW-1:0] xs, ys, at;
  logic             ccw;

  // One micro-rotation per cycle.
  always_comb begin
    xs  = x >>> cnt;
    ys  = y >>> cnt;
    at  = ATAN_TAB[ATAN_IDX_W'(cnt)];
    ccw = vec ? (y <= 0) : (z >= 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        vec  <= cmd.vec;
        cnt  <= '0;
        x    <= cmd.x0;
        y    <= cmd.y0;
        z    <= cmd.z0;
      end else if (busy) begin
        if (ccw) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

// File: tb/sv/go_to_goal_pose_controller_core_test.sv
`timescale 1ns / 1ps

module go_to_goal_pose_controller_core_test;
  import ggpc_pkg::*;

  // One velocity command as the block reports it.
  typedef struct {
    logic [13:0]        fwd;
    logic signed [14:0] lat;
    logic signed [14:0] turn;
    logic [1:0]         phase;
    logic               arrived;
  } command_t;

  // Predicts the controller and holds the commands still to come.
  class pose_scoreboard;
    longint gx = -102, gy = 1638, radius = 205, turn_ang = 21447, turn_tol = 655;
    longint lim_fwd = 2294, lim_lat = 819, lim_turn = 5734;
    bit     navigating, rotating, have_pose, have_yaw;
    longint rot_goal, px, py, yaw;
    command_t commands[$];
    int     errors;

    function longint round_shift(longint v, int s);
      longint m;
      m = v < 0 ? -v : v;
      m = (m + (64'sd1 <<< (s - 1))) >>> s;
      return v < 0 ? -m : m;
    endfunction

    function longint wrap_angle(longint a);
      longint p, tp;
      p = round_shift(longint'(PI_Q30), ANG_SHIFT);
      tp = 2 * p;
      if (a > p) a -= ((a - p + tp - 1) / tp) * tp;
      if (a < -p) a += ((-p - a + tp - 1) / tp) * tp;
      return a;
    endfunction

    function longint limit(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] v);
      case (idx)
        CFG_GOAL_X:   gx = longint'($signed(v));
        CFG_GOAL_Y:   gy = longint'($signed(v));
        CFG_RADIUS:   radius = v[12:0];
        CFG_TURN_ANG: turn_ang = v[14:0];
        CFG_TURN_TOL: turn_tol = v[13:0];
        CFG_MAX_FWD:  lim_fwd = v[13:0];
        CFG_MAX_LAT:  lim_lat = v[13:0];
        default:      lim_turn = v[13:0];
      endcase
    endfunction

    // Rotation mode CORDIC: cosine and sine of a Q.13 angle, in Q.30.
    function void sin_cos(longint ang, output longint c, output longint s);
      longint z, x, y, nx;
      bit     flip;
      z = wrap_angle(ang) * (64'sd1 <<< ANG_SHIFT);
      x = GAIN_Q30;
      y = 0;
      flip = 0;
      if (z > HALF_PI_Q30) begin
        z -= PI_Q30;
        flip = 1;
      end else if (z < -HALF_PI_Q30) begin
        z += PI_Q30;
        flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= ATAN_TAB[i];
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z += ATAN_TAB[i];
        end
        x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    // Vectoring mode CORDIC: bearing of the offset in Q.13.
    function longint bearing(longint dy, longint dx);
      longint x, y, z, nx;
      if (dx == 0 && dy == 0) return 0;
      x = dx * 4096;
      y = dy * 4096;
      z = 0;
      if (x < 0) begin
        z = y >= 0 ? longint'(PI_Q30) : -longint'(PI_Q30);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i); y = y - (x >>> i); z += ATAN_TAB[i];
        end else begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= ATAN_TAB[i];
        end
        x = nx;
      end
      return wrap_angle(round_shift(z, ANG_SHIFT));
    endfunction

    // Updates the state for an accepted item and queues any command it causes.
    function void note_item(op_t op, logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] hd, logic pv);
      longint fwd, lat, turn, dx, dy, err, c, s, fb, lb;
      command_t cmd;
      fwd = 0; lat = 0; turn = 0;
      cmd.phase = PH_WAIT;
      cmd.arrived = 0;
      case (op)
        OP_START: begin
          navigating = 1;
          rotating = 0;
          return;
        end
        OP_POSE: begin
          if (pv) begin
            px = x; py = y; yaw = hd;
            have_pose = 1;
            have_yaw = 1;
          end
          return;
        end
        OP_IMU: begin
          yaw = hd;
          have_yaw = 1;
          return;
        end
        default: ;
      endcase
      if ((navigating || rotating) && have_pose && have_yaw) begin
        dx = gx - px;
        dy = gy - py;
        if (navigating && dx * dx + dy * dy <= radius * radius) begin
          navigating = 0;
          rotating = 1;
          rot_goal = wrap_angle(yaw - turn_ang);
          cmd.arrived = 1;
        end
        if (rotating) begin
          err = wrap_angle(rot_goal - yaw);
          turn = limit(round_shift(err * 88474, 16), -lim_turn, lim_turn);
          cmd.phase = PH_ROT;
          if ((err < 0 ? -err : err) <= turn_tol) begin
            rotating = 0;
            turn = 0;
            cmd.phase = PH_DONE;
          end
        end else begin
          sin_cos(yaw, c, s);
          fb = dx * c + dy * s;
          lb = dy * c - dx * s;
          fwd = limit(round_shift(round_shift(fb, 14) * 39322, VEL_SHIFT), 0, lim_fwd);
          lat = limit(round_shift(round_shift(lb, 14) * 22938, VEL_SHIFT),
                      -lim_lat, lim_lat);
          err = wrap_angle(bearing(dy, dx) - yaw);
          turn = limit(round_shift(err * 88474, 16), -lim_turn, lim_turn);
          // Slow down while the heading is far off.
          if ((err < 0 ? -err : err) > round_shift(29491, 3) && fwd > round_shift(7864, 3))
            fwd = round_shift(7864, 3);
          cmd.phase = PH_NAV;
        end
      end
      cmd.fwd = fwd[13:0];
      cmd.lat = lat[14:0];
      cmd.turn = turn[14:0];
      commands.push_back(cmd);
    endfunction

    function void check_command(command_t got);
      command_t want;
      if (commands.size() == 0) begin
        $error("unexpected command item");
        errors++;
        return;
      end
      want = commands.pop_front();
      if (got.fwd !== want.fwd) begin
        $error("forward_vel: expected %0d, got %0d", want.fwd, got.fwd);
        errors++;
      end
      if (got.lat !== want.lat) begin
        $error("lateral_vel: expected %0d, got %0d", want.lat, got.lat);
        errors++;
      end
      if (got.turn !== want.turn) begin
        $error("turn_vel: expected %0d, got %0d", want.turn, got.turn);
        errors++;
      end
      if (got.phase !== want.phase) begin
        $error("phase: expected %0d, got %0d", want.phase, got.phase);
        errors++;
      end
      if (got.arrived !== want.arrived) begin
        $error("arrived: expected %0d, got %0d", want.arrived, got.arrived);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = 0;
  logic [15:0] cfg_wdata = 0;
  bit          steady = 0;
  int          items_sent = 0;

  ggpc_cmd_if cmd ();
  ggpc_res_if res ();

  pose_scoreboard sb = new();

  go_to_goal_pose_controller_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd.sink),
    .res       (res.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    cmd.valid = 0;
    cmd.opcode = OP_START;
    cmd.pos_x = 0;
    cmd.pos_y = 0;
    cmd.heading = 0;
    cmd.pose_valid = 0;
    res.ready = 0;
  end

  // Result side stalls at random except during the steady stretch.
  always @(negedge clk) begin
    res.ready <= steady || ($urandom_range(99) >= 17);
  end

  // Watch both handshakes at the rising edge.
  always @(posedge clk) begin
    command_t got;
    if (!rst && cmd.valid && cmd.ready)
      sb.note_item(op_t'(cmd.opcode), cmd.pos_x, cmd.pos_y, cmd.heading, cmd.pose_valid);
    if (!rst && res.valid && res.ready) begin
      got.fwd = res.forward_vel;
      got.lat = res.lateral_vel;
      got.turn = res.turn_vel;
      got.phase = res.phase;
      got.arrived = res.arrived;
      sb.check_command(got);
    end
  end

  task automatic push_item(op_t op, int x, int y, int hd, bit pv);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 17) begin
      cmd.valid <= 0;
      @(negedge clk);
    end
    cmd.valid <= 1;
    cmd.opcode <= op;
    cmd.pos_x <= 16'(x);
    cmd.pos_y <= 16'(y);
    cmd.heading <= 16'(hd);
    cmd.pose_valid <= pv;
    do @(posedge clk); while (!cmd.ready);
    items_sent++;
  endtask

  task automatic write_reg(cfg_idx_t idx, int v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= 16'(v);
    sb.set_reg(idx, 16'(v));
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Wait for every command, then for the slowest tick to finish.
  task automatic drain();
    @(negedge clk);
    cmd.valid <= 0;
    while (sb.commands.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic int clip16(int v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic int any_heading();
    return int'($urandom_range(51472)) - 25736;
  endfunction

  function automatic int near(longint c, int span);
    return clip16(int'(c) + int'($urandom_range(2 * span)) - span);
  endfunction

  // Navigation runs: a start, then pose, IMU and tick items around the goal.
  task automatic random_run(int count);
    int target, span, steps, r, hd;
    target = items_sent + count;
    while (items_sent < target) begin
      steady = items_sent >= 150 && items_sent < 260;
      push_item(OP_START, $urandom, $urandom, any_heading(), 1'($urandom));
      case ($urandom_range(3))
        0: span = int'(sb.radius / 2) + 1;
        1: span = int'(sb.radius * 3) + 1;
        2: span = 2000;
        default: span = 32767;
      endcase
      steps = $urandom_range(2, 12);
      repeat (steps) begin
        r = $urandom_range(99);
        if (r < 8) begin
          push_item(op_t'($urandom_range(3)), $urandom, $urandom, any_heading(),
                    1'($urandom));
        end else if (r < 50) begin
          push_item(OP_POSE, near(sb.gx, span), near(sb.gy, span), any_heading(),
                    $urandom_range(99) < 90);
        end else if (r < 62) begin
          hd = $urandom_range(1) ? any_heading() : near(sb.rot_goal, int'(sb.turn_tol) + 300);
          if (hd > 25736) hd = 25736;
          if (hd < -25736) hd = -25736;
          push_item(OP_IMU, $urandom, $urandom, hd, 1'($urandom));
        end else begin
          push_item(OP_TICK, $urandom, $urandom, any_heading(), 1'($urandom));
        end
      end
    end
    steady = 0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: waiting, invalid pose, extremes, arrival, rotation, restart.
    push_item(OP_TICK, 0, 0, 0, 0);
    push_item(OP_START, 0, 0, 0, 0);
    push_item(OP_TICK, 0, 0, 0, 0);
    push_item(OP_POSE, 100, 100, 100, 0);
    push_item(OP_TICK, 0, 0, 0, 0);
    push_item(OP_IMU, 0, 0, 25736, 0);
    push_item(OP_TICK, 0, 0, 0, 0);
    push_item(OP_POSE, -32768, 32767, -25736, 1);
    push_item(OP_TICK, 0, 0, 0, 0);
    push_item(OP_POSE, 32767, -32768, 25736, 1);
    push_item(OP_TICK, 0, 0, 0, 0);
    push_item(OP_POSE, -2000, 3000, 0, 1);
    push_item(OP_TICK, 0, 0, 0, 0);
    push_item(OP_POSE, -102, 1638, 1000, 1);
    push_item(OP_TICK, 0, 0, 0, 0);
    push_item(OP_TICK, 0, 0, 0, 0);
    push_item(OP_START, 0, 0, 0, 0);
    push_item(OP_TICK, 0, 0, 0, 0);
    push_item(OP_IMU, 0, 0, -20447, 0);
    push_item(OP_TICK, 0, 0, 0, 0);
    push_item(OP_TICK, 0, 0, 0, 0);
    push_item(OP_IMU, -1, -1, -1, 1);
    push_item(OP_TICK, 0, 0, 0, 0);
    drain();

    random_run(110);
    drain();

    // Extremes of every register.
    write_reg(CFG_GOAL_X, 32767);
    write_reg(CFG_GOAL_Y, -32768);
    write_reg(CFG_RADIUS, 4096);
    write_reg(CFG_TURN_ANG, 25736);
    write_reg(CFG_TURN_TOL, 8192);
    write_reg(CFG_MAX_FWD, 8192);
    write_reg(CFG_MAX_LAT, 8192);
    write_reg(CFG_MAX_TURN, 8192);
    random_run(100);
    drain();

    write_reg(CFG_GOAL_X, -32768);
    write_reg(CFG_GOAL_Y, 32767);
    write_reg(CFG_RADIUS, 0);
    write_reg(CFG_TURN_ANG, 0);
    write_reg(CFG_TURN_TOL, 0);
    write_reg(CFG_MAX_FWD, 0);
    write_reg(CFG_MAX_LAT, 0);
    write_reg(CFG_MAX_TURN, 0);
    random_run(60);
    drain();

    // Random mid-range settings.
    write_reg(CFG_GOAL_X, int'($urandom_range(16000)) - 8000);
    write_reg(CFG_GOAL_Y, int'($urandom_range(16000)) - 8000);
    write_reg(CFG_RADIUS, $urandom_range(50, 1500));
    write_reg(CFG_TURN_ANG, $urandom_range(25736));
    write_reg(CFG_TURN_TOL, $urandom_range(100, 2000));
    write_reg(CFG_MAX_FWD, $urandom_range(8192));
    write_reg(CFG_MAX_LAT, $urandom_range(8192));
    write_reg(CFG_MAX_TURN, $urandom_range(8192));
    random_run(160);
    drain();

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
